// ===== sv/canonical_kmer_counter_defines.svh =====
// Assertion macros for the checker of the k-mer counter.
`ifndef CANONICAL_KMER_COUNTER_DEFINES_SVH
`define CANONICAL_KMER_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CKC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("k-mer counter check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define CKC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("k-mer counter check failed");

`endif

// ===== sv/ckc_pkg.sv =====
package ckc_pkg;

  localparam int IN_INDEX_W  = 16;
  localparam int OUT_INDEX_W = 16;
  localparam int OUT_COUNT_W = 32;
  localparam int KLEN_W      = 4;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 1;

  localparam logic [KLEN_W-1:0] KMER_LENGTH_RESET = 4'd8;

  localparam logic [CFG_INDEX_W-1:0] REG_KMER_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PICK_LARGER = 1'd1;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Output queue depth and its pointer and fill widths.
  localparam int Q_DEPTH = 3;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic is_read;
    logic is_count;
  } issue_t;

  typedef struct packed {
    logic                   kmer_valid;
    logic [OUT_INDEX_W-1:0] kmer_index;
    logic [OUT_COUNT_W-1:0] count_value;
  } out_item_t;

endpackage

// ===== sv/ckc_ram.sv =====
module ckc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/ckc_roll.sv =====
module ckc_roll #(
  parameter int MAX_KMER = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [1:0]                base_code,
  input  logic                      sequence_start,
  input  logic [ckc_pkg::KLEN_W-1:0] kmer_length,
  input  logic                      pick_larger,
  output logic [2*MAX_KMER-1:0]     canon_index,
  output logic                      full
);

  localparam int IW = 2 * MAX_KMER;
  localparam int KW = $clog2(MAX_KMER + 1);

  logic [IW-1:0] forward_word;
  logic [IW-1:0] reverse_word;
  logic [KW-1:0] bases_filled;

  logic [IW-1:0] forward_word_next;
  logic [IW-1:0] reverse_word_next;
  logic [KW-1:0] bases_filled_next;

  logic [ckc_pkg::KLEN_W-1:0] k4;
  logic [KW-1:0]              k;
  logic [KW:0]                two_k;
  logic [IW-1:0]              mask;
  logic [IW-1:0]              comp_ins;
  logic [IW+1:0]              fwd_shift;
  logic [KW-1:0]              fill_base;

  always_comb begin
    if (kmer_length == '0) begin
      k4 = ckc_pkg::KLEN_W'(1);
    end else if (kmer_length > ckc_pkg::KLEN_W'(MAX_KMER)) begin
      k4 = ckc_pkg::KLEN_W'(MAX_KMER);
    end else begin
      k4 = kmer_length;
    end
    k     = k4[KW-1:0];
    two_k = {k, 1'b0};

    for (int i = 0; i < IW; i++) begin
      mask[i] = ((KW + 1)'(i) < two_k);
    end
    // The complement of the new base lands in the top base slot of the k-mer.
    for (int j = 0; j < MAX_KMER; j++) begin
      comp_ins[2*j +: 2] = (KW'(j) == (k - KW'(1))) ? ~base_code : 2'b00;
    end

    fwd_shift         = {forward_word, base_code};
    forward_word_next = fwd_shift[IW-1:0] & mask;
    reverse_word_next = (((reverse_word & mask) >> 2) | comp_ins) & mask;

    fill_base = sequence_start ? '0 : bases_filled;
    if (fill_base < k) begin
      bases_filled_next = fill_base + KW'(1);
    end else begin
      bases_filled_next = k;
    end
    full = (bases_filled_next >= k);

    if (pick_larger) begin
      canon_index = (forward_word_next > reverse_word_next) ?
                    forward_word_next : reverse_word_next;
    end else begin
      canon_index = (forward_word_next < reverse_word_next) ?
                    forward_word_next : reverse_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_word <= '0;
      reverse_word <= '0;
      bases_filled <= '0;
    end else if (step) begin
      forward_word <= forward_word_next;
      reverse_word <= reverse_word_next;
      bases_filled <= bases_filled_next;
    end
  end

endmodule

// ===== sv/ckc_outq.sv =====
module ckc_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  ckc_pkg::out_item_t            push_item,
  input  logic                          pop,
  output logic                          not_empty,
  output ckc_pkg::out_item_t            head,
  output logic [ckc_pkg::QCNT_W-1:0]    fill
);

  ckc_pkg::out_item_t entries [ckc_pkg::Q_DEPTH];

  logic [ckc_pkg::QPTR_W-1:0] wr_ptr;
  logic [ckc_pkg::QPTR_W-1:0] rd_ptr;
  logic                       do_pop;

  function automatic logic [ckc_pkg::QPTR_W-1:0] bump(
    input logic [ckc_pkg::QPTR_W-1:0] p
  );
    return (p == ckc_pkg::QPTR_W'(ckc_pkg::Q_DEPTH - 1)) ? '0 : p + ckc_pkg::QPTR_W'(1);
  endfunction

  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !do_pop) begin
        fill <= fill + ckc_pkg::QCNT_W'(1);
      end else if (!push && do_pop) begin
        fill <= fill - ckc_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/canonical_kmer_counter.sv =====
// Channel  | Handshake                    | Payload
// ---------+------------------------------+--------------------------------------------
// input    | in_valid / in_stall          | operation, base_code, sequence_start,
//          |                              | entry_index
// output   | out_valid / out_stall        | kmer_valid, kmer_index, count_value
// config   | cfg_write (no handshake)     | cfg_index, cfg_data
//
// One item per cycle is accepted while in_stall is low; its result passes the read stage
// register and then the output queue before it is shown. The rate is set by the count
// table's single read and single write port: each item reads its entry when accepted,
// and a counting item writes it back in the following cycle, with a bypass of the last
// write. After reset, in_stall stays high while the 4**MAX_KMER table entries are cleared
// one entry a cycle. A three-item output queue absorbs out_stall; apart from clearing,
// in_stall rises only when that queue and the read stage together are full.
module canonical_kmer_counter #(
  parameter int MAX_KMER   = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ckc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ckc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [1:0]                          base_code,
  input  logic                                sequence_start,
  input  logic [ckc_pkg::IN_INDEX_W-1:0]      entry_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                kmer_valid,
  output logic [ckc_pkg::OUT_INDEX_W-1:0]     kmer_index,
  output logic [ckc_pkg::OUT_COUNT_W-1:0]     count_value
);

  localparam int IW    = 2 * MAX_KMER;
  localparam int DEPTH = 1 << IW;

  // Configuration registers.
  logic [ckc_pkg::KLEN_W-1:0] kmer_length;
  logic                       pick_larger;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= ckc_pkg::KMER_LENGTH_RESET;
      pick_larger <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        ckc_pkg::REG_KMER_LENGTH: kmer_length <= cfg_data;
        ckc_pkg::REG_PICK_LARGER: pick_larger <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Table clearing after reset.
  logic          clearing;
  logic [IW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + IW'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Issue stage.
  logic                       accept;
  logic                       step;
  logic [IW-1:0]              canon_index;
  logic                       full;
  logic [IW+ckc_pkg::IN_INDEX_W-1:0] entry_wide;
  logic [IW-1:0]              rd_addr;
  ckc_pkg::issue_t            issue;
  logic [ckc_pkg::QCNT_W-1:0] q_fill;
  logic                       q_not_empty;

  assign accept = in_valid && !in_stall;
  assign step   = accept && (operation == ckc_pkg::OP_FEED);

  ckc_roll #(
    .MAX_KMER(MAX_KMER)
  ) u_roll (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .base_code     (base_code),
    .sequence_start(sequence_start),
    .kmer_length   (kmer_length),
    .pick_larger   (pick_larger),
    .canon_index   (canon_index),
    .full          (full)
  );

  assign entry_wide     = {{IW{1'b0}}, entry_index};
  assign rd_addr        = (operation == ckc_pkg::OP_READ) ? entry_wide[IW-1:0] : canon_index;
  assign issue.is_read  = (operation == ckc_pkg::OP_READ);
  assign issue.is_count = (operation == ckc_pkg::OP_FEED) && full;

  // Read stage: registers that travel with the table read.
  logic            s1_valid;
  ckc_pkg::issue_t s1_ctl;
  logic [IW-1:0]   s1_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= issue;
      s1_idx <= rd_addr;
    end
  end

  assign in_stall = clearing ||
                    (({1'b0, q_fill} + (ckc_pkg::QCNT_W + 1)'(s1_valid)) >=
                     (ckc_pkg::QCNT_W + 1)'(ckc_pkg::Q_DEPTH));

  // Count table and write-back bypass.
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  byp_valid;
  logic [IW-1:0]         byp_idx;
  logic [COUNT_BITS-1:0] byp_data;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] inc_count;

  ckc_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // The item in the read stage was read while the previous item was being
  // written, so a matching index takes the value from the last write.
  assign cur_count = (byp_valid && (byp_idx == s1_idx)) ? byp_data : rd_data;
  assign inc_count = (cur_count == '1) ? cur_count : cur_count + COUNT_BITS'(1);

  assign wr_en   = clearing || (s1_valid && s1_ctl.is_count);
  assign wr_addr = clearing ? clr_addr : s1_idx;
  assign wr_data = clearing ? '0 : inc_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    byp_idx  <= wr_addr;
    byp_data <= wr_data;
  end

  // Result formation.
  logic [IW+ckc_pkg::OUT_INDEX_W-1:0]         idx_wide;
  logic [COUNT_BITS+ckc_pkg::OUT_COUNT_W-1:0] cnt_wide;
  logic [COUNT_BITS-1:0]                      res_count;
  ckc_pkg::out_item_t                         res_item;
  ckc_pkg::out_item_t                         head;

  always_comb begin
    if (s1_ctl.is_count) begin
      res_count = inc_count;
    end else if (s1_ctl.is_read) begin
      res_count = cur_count;
    end else begin
      res_count = '0;
    end
    idx_wide = {{ckc_pkg::OUT_INDEX_W{1'b0}}, s1_idx};
    cnt_wide = {{ckc_pkg::OUT_COUNT_W{1'b0}}, res_count};
    res_item.kmer_valid  = s1_ctl.is_read || s1_ctl.is_count;
    res_item.kmer_index  = res_item.kmer_valid ? idx_wide[ckc_pkg::OUT_INDEX_W-1:0] : '0;
    res_item.count_value = cnt_wide[ckc_pkg::OUT_COUNT_W-1:0];
  end

  ckc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_valid),
    .push_item(res_item),
    .pop      (!out_stall),
    .not_empty(q_not_empty),
    .head     (head),
    .fill     (q_fill)
  );

  assign out_valid   = q_not_empty;
  assign kmer_valid  = head.kmer_valid;
  assign kmer_index  = head.kmer_index;
  assign count_value = head.count_value;

endmodule

// ===== sv/ckc_check.sv =====
`include "canonical_kmer_counter_defines.svh"

module ckc_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_write,
  input logic [ckc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [ckc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            operation,
  input logic [1:0]                      base_code,
  input logic                            sequence_start,
  input logic [ckc_pkg::IN_INDEX_W-1:0]  entry_index,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            kmer_valid,
  input logic [ckc_pkg::OUT_INDEX_W-1:0] kmer_index,
  input logic [ckc_pkg::OUT_COUNT_W-1:0] count_value
);

  // A result that is held back stays in place unchanged.
  `CKC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kmer_valid) && $stable(kmer_index) && $stable(count_value))

  // A base that completes no k-mer reports all-zero fields.
  `CKC_ASSERT_NOW(a_empty_result, out_valid && !kmer_valid, (kmer_index == '0) && (count_value == '0))

  // The table is being cleared right after reset, so no item may enter.
  `CKC_ASSERT_NOW(a_clear_after_reset, $fell(rst), in_stall)

endmodule

bind canonical_kmer_counter ckc_check u_check (.*);
